FILE: rtl/core/bmr_pkg.sv
// Shared types and constants for the boundary matrix reduction block.
// Used by bmr_ctrl, bmr_dp and flat_boundary_matrix_reduction; no dependencies.
package bmr_pkg;

	localparam int NSIMP = 64;
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;
	localparam int DIM_W = 3;

	typedef struct packed {
		logic [DIM_W-1:0] simplex_dim;
		logic [NSIMP-1:0] face_mask;
		logic             last_column;
	} column_t;

	typedef struct packed {
		logic [DIM_W-1:0] pair_dim;
		logic [IDX_W-1:0] birth_index;
		logic [IDX_W-1:0] death_index;
		logic             death_infinite;
		logic             last_pair;
	} pair_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic idx_clr;
		logic idx_inc;
		logic rd_owner;
		logic col_load;
		logic col_xor;
		logic low_cap;
		logic claim;
		logic col_wb;
		logic emit_fin;
		logic emit_inf;
		logic flush;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic col_zero;
		logic owned;
		logic idx_end;
		logic rd_zero;
		logic marked;
	} status_t;

	typedef enum logic [11:0] {
		ST_LOAD  = 12'b0000_0000_0001,
		ST_R_RD  = 12'b0000_0000_0010,
		ST_R_LD  = 12'b0000_0000_0100,
		ST_R_LOW = 12'b0000_0000_1000,
		ST_R_OWN = 12'b0000_0001_0000,
		ST_R_CHK = 12'b0000_0010_0000,
		ST_R_XOR = 12'b0000_0100_0000,
		ST_E_RD  = 12'b0000_1000_0000,
		ST_E_CHK = 12'b0001_0000_0000,
		ST_I_RD  = 12'b0010_0000_0000,
		ST_I_CHK = 12'b0100_0000_0000,
		ST_FLUSH = 12'b1000_0000_0000
	} state_t;

endpackage

FILE: rtl/core/bmr_ctrl.sv
// Sequencer for load, reduction, finite-pair and essential-pair passes.
// Depends on bmr_pkg (cmd_t, status_t, state_t).
module bmr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             last_column,
	input  bmr_pkg::status_t status,
	output bmr_pkg::cmd_t    cmd,
	output logic             busy
);

	bmr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmr_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != bmr_pkg::ST_LOAD);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			bmr_pkg::ST_LOAD: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_column) begin
						cmd.idx_clr = 1'b1;
						state_d     = bmr_pkg::ST_R_RD;
					end
				end
			end
			bmr_pkg::ST_R_RD: begin
				state_d = bmr_pkg::ST_R_LD;
			end
			bmr_pkg::ST_R_LD: begin
				cmd.col_load = 1'b1;
				state_d      = bmr_pkg::ST_R_LOW;
			end
			bmr_pkg::ST_R_LOW: begin
				if (status.col_zero) begin
					cmd.col_wb = 1'b1;
					if (status.idx_end) begin
						cmd.idx_clr = 1'b1;
						state_d     = bmr_pkg::ST_E_RD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = bmr_pkg::ST_R_RD;
					end
				end else begin
					cmd.low_cap = 1'b1;
					state_d     = bmr_pkg::ST_R_OWN;
				end
			end
			bmr_pkg::ST_R_OWN: begin
				state_d = bmr_pkg::ST_R_CHK;
			end
			bmr_pkg::ST_R_CHK: begin
				if (status.owned) begin
					cmd.rd_owner = 1'b1;
					state_d      = bmr_pkg::ST_R_XOR;
				end else begin
					cmd.claim  = 1'b1;
					cmd.col_wb = 1'b1;
					if (status.idx_end) begin
						cmd.idx_clr = 1'b1;
						state_d     = bmr_pkg::ST_E_RD;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = bmr_pkg::ST_R_RD;
					end
				end
			end
			bmr_pkg::ST_R_XOR: begin
				cmd.col_xor = 1'b1;
				state_d     = bmr_pkg::ST_R_LOW;
			end
			bmr_pkg::ST_E_RD: begin
				state_d = bmr_pkg::ST_E_CHK;
			end
			bmr_pkg::ST_E_CHK: begin
				cmd.emit_fin = !status.rd_zero;
				if (status.idx_end) begin
					cmd.idx_clr = 1'b1;
					state_d     = bmr_pkg::ST_I_RD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = bmr_pkg::ST_E_RD;
				end
			end
			bmr_pkg::ST_I_RD: begin
				state_d = bmr_pkg::ST_I_CHK;
			end
			bmr_pkg::ST_I_CHK: begin
				cmd.emit_inf = !status.marked;
				if (status.idx_end) begin
					state_d = bmr_pkg::ST_FLUSH;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = bmr_pkg::ST_I_RD;
				end
			end
			bmr_pkg::ST_FLUSH: begin
				cmd.flush   = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d     = bmr_pkg::ST_LOAD;
			end
			default: begin
				state_d = bmr_pkg::ST_LOAD;
			end
		endcase
	end

endmodule

FILE: rtl/core/bmr_dp.sv
// Datapath: column store, pivot owner table, working column, pair output.
// Depends on bmr_pkg; driven by bmr_ctrl through cmd_t / status_t.
module bmr_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  bmr_pkg::column_t column,
	input  bmr_pkg::cmd_t    cmd,
	output bmr_pkg::status_t status,
	output bmr_pkg::pair_t   pair,
	output logic             pair_valid
);

	function automatic logic [bmr_pkg::IDX_W-1:0] top_bit(input logic [bmr_pkg::NSIMP-1:0] v);
		logic [bmr_pkg::IDX_W-1:0] k;
		k = '0;
		for (int b = 0; b < bmr_pkg::NSIMP; b++) begin
			if (v[b]) k = bmr_pkg::IDX_W'(b);
		end
		return k;
	endfunction

	// memories
	logic [bmr_pkg::NSIMP-1:0] bcol_mem [bmr_pkg::NSIMP];
	logic [bmr_pkg::DIM_W-1:0] dim_mem  [bmr_pkg::NSIMP];
	logic [bmr_pkg::IDX_W-1:0] own_mem  [bmr_pkg::NSIMP];

	// control state
	logic [bmr_pkg::CNT_W-1:0] count_q;
	logic [bmr_pkg::IDX_W-1:0] idx_q;
	logic [bmr_pkg::NSIMP-1:0] valid_q;
	logic [bmr_pkg::NSIMP-1:0] marks_q;
	logic                      pend_v_q;
	logic                      out_v_q;

	// payload
	logic [bmr_pkg::NSIMP-1:0] rd_q;
	logic [bmr_pkg::DIM_W-1:0] dim_rd_q;
	logic [bmr_pkg::IDX_W-1:0] own_rd_q;
	logic [bmr_pkg::NSIMP-1:0] col_q;
	logic [bmr_pkg::IDX_W-1:0] low_q;
	bmr_pkg::pair_t            pend_q;
	bmr_pkg::pair_t            out_q;

	logic                      load_ok;
	logic [bmr_pkg::NSIMP-1:0] keep;
	logic                      bwr_en;
	logic [bmr_pkg::IDX_W-1:0] bwr_addr;
	logic [bmr_pkg::NSIMP-1:0] bwr_data;
	logic [bmr_pkg::IDX_W-1:0] rd_addr;
	logic                      emit;
	bmr_pkg::pair_t            new_pair;
	bmr_pkg::pair_t            out_d;

	assign load_ok  = cmd.load && !count_q[bmr_pkg::CNT_W-1];
	assign keep     = ~({bmr_pkg::NSIMP{1'b1}} << count_q[bmr_pkg::IDX_W-1:0]);
	assign bwr_en   = load_ok || cmd.col_wb;
	assign bwr_addr = cmd.load ? count_q[bmr_pkg::IDX_W-1:0] : idx_q;
	assign bwr_data = cmd.load ? (column.face_mask & keep) : col_q;
	assign rd_addr  = cmd.rd_owner ? own_rd_q : idx_q;

	always_ff @(posedge clk) begin
		if (bwr_en) begin
			bcol_mem[bwr_addr] <= bwr_data;
		end
		rd_q <= bcol_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			dim_mem[count_q[bmr_pkg::IDX_W-1:0]] <= column.simplex_dim;
		end
		dim_rd_q <= dim_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.claim) begin
			own_mem[low_q] <= idx_q;
		end
		own_rd_q <= own_mem[low_q];
	end

	// working column and pivot row
	always_ff @(posedge clk) begin
		if (cmd.col_load) begin
			col_q <= rd_q;
		end else if (cmd.col_xor) begin
			col_q <= col_q ^ rd_q;
		end
		if (cmd.low_cap) begin
			low_q <= top_bit(col_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			valid_q <= '0;
			marks_q <= '0;
		end else begin
			if (cmd.flush) begin
				count_q <= '0;
				valid_q <= '0;
				marks_q <= '0;
			end else begin
				if (load_ok) begin
					count_q <= count_q + bmr_pkg::CNT_W'(1);
				end
				if (cmd.claim) begin
					valid_q[low_q] <= 1'b1;
					marks_q        <= marks_q
					                  | (bmr_pkg::NSIMP'(1) << low_q)
					                  | (bmr_pkg::NSIMP'(1) << idx_q);
				end
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + bmr_pkg::IDX_W'(1);
			end
		end
	end

	// new pair from the current pass
	always_comb begin
		new_pair = '0;
		if (cmd.emit_fin) begin
			new_pair.pair_dim    = dim_rd_q - bmr_pkg::DIM_W'(1);
			new_pair.birth_index = top_bit(rd_q);
			new_pair.death_index = idx_q;
		end else begin
			new_pair.pair_dim       = dim_rd_q;
			new_pair.birth_index    = idx_q;
			new_pair.death_infinite = 1'b1;
		end
	end

	assign emit = cmd.emit_fin || cmd.emit_inf;

	// held pair goes out flagged last when the flush pushes it
	always_comb begin
		out_d           = pend_q;
		out_d.last_pair = cmd.flush;
	end

	// one pair held back so the final one can be flagged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			out_v_q <= pend_v_q && (emit || cmd.flush);
			if (emit) begin
				pend_v_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pend_q <= new_pair;
		end
		if (emit || cmd.flush) begin
			out_q <= out_d;
		end
	end

	assign pair       = out_q;
	assign pair_valid = out_v_q;

	assign status.col_zero = (col_q == '0);
	assign status.owned    = valid_q[low_q];
	assign status.idx_end  = ({1'b0, idx_q} + bmr_pkg::CNT_W'(1)) == count_q;
	assign status.rd_zero  = (rd_q == '0);
	assign status.marked   = marks_q[idx_q];

`ifndef NO_ASSERTIONS
	a_last_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> out_v_q && out_q.last_pair)
		else $error("final pair of the run not strobed with last_pair");
	a_claim_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.claim |-> !valid_q[low_q] && (col_q != '0))
		else $error("pivot claimed twice or by an empty column");
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (count_q == '0) && (valid_q == '0) && !pend_v_q)
		else $error("run state not cleared after flush");
	a_no_emit_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_ok |-> !emit && !cmd.col_wb)
		else $error("column write collides with reduction");
`endif

endmodule

FILE: rtl/core/flat_boundary_matrix_reduction.sv
// Load: one column per cycle while busy is low. After the last column, busy stays high
// for the run: reduction reads each column, then claims its pivot or adds the owner
// column (one memory read of the owner column each) until it ends empty or claims;
// then a finite-pair pass, an essential-pair pass and a flush follow.
// Pairs leave as single-cycle pulses on pair_valid; the receiver cannot stall.
// arst_n clears the run state (column count, pivot valid bits, marks, sequencer).
module flat_boundary_matrix_reduction (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  bmr_pkg::column_t column,
	output logic             busy,
	output bmr_pkg::pair_t   pair,
	output logic             pair_valid
);

	// Controller and datapath talk only through these two bundles.
	bmr_pkg::cmd_t    cmd;
	bmr_pkg::status_t status;

	// Sequencer: an item is taken when start is high in the load state; the
	// item flagged last_column kicks off reduction and both output passes.
	bmr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_column (column.last_column),
		.status      (status),
		.cmd         (cmd),
		.busy        (busy)
	);

	// Datapath: column memory with the lowest-one search, pivot owner table
	// with per-row valid bits, used-simplex marks and a one-deep pair buffer
	// that lets the final pair carry last_pair.
	bmr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.column     (column),
		.cmd        (cmd),
		.status     (status),
		.pair       (pair),
		.pair_valid (pair_valid)
	);

endmodule
